/* src/adpe_pkg.sv */
// adpe_pkg: shared types and constants for the data processing execute block
`timescale 1ns / 1ps
`default_nettype none
package adpe_pkg;

	typedef struct packed {
		logic        kind;
		logic [31:0] instruction_word;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        write_enable;
		logic [3:0]  dest_index;
		logic [31:0] write_value;
		logic [3:0]  flags;
	} out_item_t;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_SKIP    = 2'd1;
	localparam logic [1:0] ST_BADCOND = 2'd2;
	localparam logic [1:0] ST_BADOP   = 2'd3;

	localparam logic [3:0] CC_EQ = 4'd0;
	localparam logic [3:0] CC_NE = 4'd1;
	localparam logic [3:0] CC_GE = 4'd10;
	localparam logic [3:0] CC_LT = 4'd11;
	localparam logic [3:0] CC_GT = 4'd12;
	localparam logic [3:0] CC_LE = 4'd13;
	localparam logic [3:0] CC_AL = 4'd14;

	localparam logic [3:0] OP_AND = 4'd0;
	localparam logic [3:0] OP_EOR = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_RSB = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_TST = 4'd8;
	localparam logic [3:0] OP_TEQ = 4'd9;
	localparam logic [3:0] OP_CMP = 4'd10;
	localparam logic [3:0] OP_ORR = 4'd12;
	localparam logic [3:0] OP_MOV = 4'd13;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	typedef struct packed {
		logic [31:0] value;
		logic        carry;
	} shift_res_t;

endpackage
`default_nettype wire

/* src/adpe_shifter.sv */
// adpe_shifter: operand 2 barrel shifter with carry out
`timescale 1ns / 1ps
`default_nettype none
module adpe_shifter (
	input  wire logic [11:0]  op2,
	input  wire logic         imm,
	input  wire logic [31:0]  rm_val,
	input  wire logic [7:0]   rs_byte,
	input  wire logic         cin,
	output adpe_pkg::shift_res_t res
);
	logic [4:0]  rot;
	logic [31:0] imm_rot;
	logic [1:0]  sh;
	logic [7:0]  amt;
	logic        sign;
	logic [63:0] dbl;

	always_comb begin
		rot     = {op2[11:8], 1'b0};
		dbl     = {24'd0, op2[7:0], 24'd0, op2[7:0]} >> rot;
		imm_rot = dbl[31:0];
		sh      = op2[6:5];
		sign    = rm_val[31];
		res.value = rm_val;
		res.carry = cin;
		if (op2[4]) amt = rs_byte;
		else amt = {3'd0, op2[11:7]};
		if (imm) begin
			res.value = imm_rot;
			res.carry = (rot == 5'd0) ? cin : imm_rot[31];
		end else if (!op2[4] && amt == 8'd0) begin
			// constant zero amounts: lsl passes, lsr/asr mean 32, ror is rrx
			case (sh)
				adpe_pkg::SH_LSL: begin res.value = rm_val; res.carry = cin; end
				adpe_pkg::SH_LSR: begin res.value = 32'd0; res.carry = sign; end
				adpe_pkg::SH_ASR: begin res.value = {32{sign}}; res.carry = sign; end
				default: begin res.value = {cin, rm_val[31:1]}; res.carry = rm_val[0]; end
			endcase
		end else if (amt == 8'd0) begin
			res.value = rm_val;
			res.carry = cin;
		end else begin
			case (sh)
				adpe_pkg::SH_LSL: begin
					if (amt < 8'd32) begin
						res.value = rm_val << amt[4:0];
						// bit 32 - amt, taken modulo 32
						res.carry = rm_val[5'd0 - amt[4:0]];
					end else begin
						res.value = 32'd0;
						res.carry = (amt == 8'd32) ? rm_val[0] : 1'b0;
					end
				end
				adpe_pkg::SH_LSR: begin
					if (amt < 8'd32) begin
						res.value = rm_val >> amt[4:0];
						res.carry = rm_val[amt[4:0] - 5'd1];
					end else begin
						res.value = 32'd0;
						res.carry = (amt == 8'd32) ? sign : 1'b0;
					end
				end
				adpe_pkg::SH_ASR: begin
					if (amt < 8'd32) begin
						res.value = 32'($signed(rm_val) >>> amt[4:0]);
						res.carry = rm_val[amt[4:0] - 5'd1];
					end else begin
						res.value = {32{sign}};
						res.carry = sign;
					end
				end
				default: begin
					res.value = (rm_val >> amt[4:0]) | (rm_val << (6'd32 - {1'b0, amt[4:0]}));
					res.carry = rm_val[amt[4:0] - 5'd1];
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/arm_data_processing_execute.sv */
// arm_data_processing_execute: condition check, alu, multiply and register file
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_data  (adpe_pkg::in_item_t)
//  output  | out_valid | out_stall | out_data (adpe_pkg::out_item_t)
//
//  an item is registered on acceptance; one item per cycle is sustained without
//  output stalls; the registered input, alu and 32x32 multiply form the single
//  combinational pass, state updates when the result registers; reset clears the
//  register file, the flags and both valid registers; a stalled output holds;
//  the input stalls only when both registers are full and the output stalls
`timescale 1ns / 1ps
`default_nettype none
module arm_data_processing_execute #(
	parameter int REG_COUNT = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire adpe_pkg::in_item_t  in_data,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      adpe_pkg::out_item_t out_data
);
	localparam int IW = $clog2(REG_COUNT);

	logic                v_s1;
	adpe_pkg::in_item_t  d_s1;
	logic [31:0]         regs_q [REG_COUNT];
	logic [3:0]          flags_q;
	adpe_pkg::out_item_t res;
	adpe_pkg::shift_res_t sres;
	logic                adv;

	// stage 1 moves when the output register is free or being taken
	assign adv      = !out_valid || !out_stall;
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv || !v_s1) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if ((adv || !v_s1) && in_valid) d_s1 <= in_data;
	end

	logic [31:0] w;
	logic        n, z, v, cpass, csup;
	logic [31:0] rn, op2v, prod;
	logic [32:0] sum;
	logic        c;
	logic [3:0]  opc;

	assign w = d_s1.instruction_word;
	assign n = flags_q[3];
	assign z = flags_q[2];
	assign v = flags_q[0];

	adpe_shifter u_shift (
		.op2    (w[11:0]),
		.imm    (w[25]),
		.rm_val (regs_q[w[IW-1:0]]),
		.rs_byte(regs_q[w[8+IW-1:8]][7:0]),
		.cin    (flags_q[1]),
		.res    (sres)
	);

	// condition decode
	always_comb begin
		csup = 1'b1;
		unique case (w[31:28])
			adpe_pkg::CC_EQ: cpass = z;
			adpe_pkg::CC_NE: cpass = !z;
			adpe_pkg::CC_GE: cpass = n == v;
			adpe_pkg::CC_LT: cpass = n != v;
			adpe_pkg::CC_GT: cpass = !z && (n == v);
			adpe_pkg::CC_LE: cpass = z || (n != v);
			adpe_pkg::CC_AL: cpass = 1'b1;
			default: begin cpass = 1'b0; csup = 1'b0; end
		endcase
	end

	// execute
	always_comb begin
		rn   = regs_q[w[16+IW-1:16]];
		op2v = sres.value;
		opc  = w[24:21];
		prod = regs_q[w[IW-1:0]] * regs_q[w[8+IW-1:8]];
		sum  = 33'd0;
		c    = sres.carry;
		res  = '0;
		res.flags = flags_q;
		if (!cpass) begin
			res.status = csup ? adpe_pkg::ST_SKIP : adpe_pkg::ST_BADCOND;
		end else if (d_s1.kind) begin
			res.dest_index   = w[19:16];
			res.write_value  = prod + (w[21] ? regs_q[w[12+IW-1:12]] : 32'd0);
			res.write_enable = 1'b1;
			if (w[20]) begin
				res.flags[3] = res.write_value[31];
				res.flags[2] = res.write_value == 32'd0;
			end
		end else begin
			case (opc) inside
				adpe_pkg::OP_AND, adpe_pkg::OP_TST: res.write_value = rn & op2v;
				adpe_pkg::OP_EOR, adpe_pkg::OP_TEQ: res.write_value = rn ^ op2v;
				adpe_pkg::OP_ORR: res.write_value = rn | op2v;
				adpe_pkg::OP_MOV: res.write_value = op2v;
				adpe_pkg::OP_SUB, adpe_pkg::OP_CMP: begin
					sum = {1'b0, rn} + {1'b0, ~op2v} + 33'd1;
					res.write_value = sum[31:0];
					c = sum[32];
				end
				adpe_pkg::OP_RSB: begin
					sum = {1'b0, op2v} + {1'b0, ~rn} + 33'd1;
					res.write_value = sum[31:0];
					c = sum[32];
				end
				adpe_pkg::OP_ADD: begin
					sum = {1'b0, rn} + {1'b0, op2v};
					res.write_value = sum[31:0];
					c = sum[32];
				end
				default: res.status = adpe_pkg::ST_BADOP;
			endcase
			if (res.status == adpe_pkg::ST_DONE) begin
				res.dest_index   = w[15:12];
				res.write_enable = !(opc == adpe_pkg::OP_TST || opc == adpe_pkg::OP_TEQ
					|| opc == adpe_pkg::OP_CMP);
				if (w[20]) begin
					res.flags[3] = res.write_value[31];
					res.flags[2] = res.write_value == 32'd0;
					res.flags[1] = c;
				end
			end else begin
				res.write_value = 32'd0;
			end
		end
	end

	// result register and state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			flags_q   <= 4'd0;
			for (int i = 0; i < REG_COUNT; i++) regs_q[i] <= 32'd0;
		end else if (adv) begin
			out_valid <= v_s1;
			if (v_s1 && res.status == adpe_pkg::ST_DONE) begin
				flags_q <= res.flags;
				if (res.write_enable) regs_q[res.dest_index[IW-1:0]] <= res.write_value;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv && v_s1) out_data <= res;
	end
endmodule
`default_nettype wire

/* src/adpe_checker.sv */
// adpe_checker: port level checks for the execute block
`timescale 1ns / 1ps
`default_nettype none
module adpe_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire adpe_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire adpe_pkg::out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled item changed");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != adpe_pkg::ST_DONE |->
		!out_data.write_enable && out_data.write_value == 32'd0)
		else $error("not executed item writes");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall |=> out_valid)
		else $error("accepted item lost");
endmodule

bind arm_data_processing_execute adpe_checker u_chk (.*);
`default_nettype wire
